>>> hdl/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg - shared types and constants for the watchdog supervisor
// Command codes, status codes, result kinds, reset values and the base table.
// ----------------------------------------------------------------------------
package swc_pkg;

  // result kinds
  localparam logic [1:0] KIND_RESP   = 2'd0;
  localparam logic [1:0] KIND_REBOOT = 2'd1;
  localparam logic [1:0] KIND_SELF   = 2'd2;

  // status codes
  localparam logic [15:0] ST_SUCCESS = 16'd0;
  localparam logic [15:0] ST_ERROR   = 16'd1;
  localparam logic [15:0] ST_INVALID = 16'd2;
  localparam logic [15:0] ST_PING    = 16'd3;
  localparam logic [15:0] ST_LOCKED  = 16'd4;

  localparam logic [15:0] VERSION_WORD = 16'd210;
  localparam logic [15:0] DATE_WORD    = 16'h0804;

  // command codes
  localparam logic [7:0] CMD_PING       = 8'd0;
  localparam logic [7:0] CMD_UNLOCK     = 8'd1;
  localparam logic [7:0] CMD_LOCK       = 8'd2;
  localparam logic [7:0] CMD_VERSION    = 8'd3;
  localparam logic [7:0] CMD_DATE       = 8'd4;
  localparam logic [7:0] CMD_REBOOT     = 8'd6;
  localparam logic [7:0] CMD_CLR_FAULTS = 8'd7;
  localparam logic [7:0] CMD_RD_FAULTS  = 8'd8;
  localparam logic [7:0] CMD_RD_FAULTS2 = 8'd9;
  localparam logic [7:0] CMD_MODE_GUARD = 8'd11;
  localparam logic [7:0] CMD_MODE_SLEEP = 8'd12;
  localparam logic [7:0] CMD_SELF_RESET = 8'd13;
  localparam logic [7:0] CMD_MODE_BEAC  = 8'd14;
  localparam logic [7:0] CMD_ENABLE     = 8'd30;
  localparam logic [7:0] CMD_DISABLE    = 8'd31;
  localparam logic [7:0] CMD_HEARTBEAT  = 8'd32;
  localparam logic [7:0] CMD_BASE_LO    = 8'd40;
  localparam logic [7:0] CMD_BASE_HI    = 8'd49;
  localparam logic [7:0] CMD_MULT_LO    = 8'd50;
  localparam logic [7:0] CMD_MULT_HI    = 8'd69;
  localparam logic [7:0] MULT_OFFSET    = 8'd49;

  // interval modes
  localparam logic [1:0] MODE_GUARD  = 2'd0;
  localparam logic [1:0] MODE_SLEEP  = 2'd1;
  localparam logic [1:0] MODE_BEACON = 2'd2;

  localparam logic [2:0] BASE_ENTRIES = 3'd7;

  // reset values
  localparam logic [6:0] RST_GUARD_BASE  = 7'd15;
  localparam logic [4:0] RST_GUARD_MULT  = 5'd8;
  localparam logic [6:0] RST_SLEEP_BASE  = 7'd15;
  localparam logic [4:0] RST_SLEEP_MULT  = 5'd8;
  localparam logic [6:0] RST_BEACON_BASE = 7'd5;
  localparam logic [4:0] RST_BEACON_MULT = 5'd2;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic        last;
  } swc_res_t;

  // results of one item, handed from the core to the output queue
  typedef struct packed {
    logic [1:0] count;
    swc_res_t   res0;
    swc_res_t   res1;
  } swc_push_t;

  function automatic logic [6:0] base_lookup(input logic [2:0] sel);
    logic [6:0] b;
    unique case (sel)
      3'd0:    b = 7'd1;
      3'd1:    b = 7'd5;
      3'd2:    b = 7'd10;
      3'd3:    b = 7'd15;
      3'd4:    b = 7'd30;
      3'd5:    b = 7'd60;
      3'd6:    b = 7'd90;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/supervisor_watchdog_with_commands.sv
// ----------------------------------------------------------------------------
// supervisor_watchdog_with_commands - external watchdog supervisor
// Accepts ticks and command bytes; returns response words and reboot events.
// ----------------------------------------------------------------------------
// Result path: an input beat that is taken is held in the input register, then
//   decoded into the result queue, from which its first result beat is taken.
// Throughput: one input beat per cycle while the queue has room; a timeout tick
//   yields two output beats, so the one-beat-per-cycle queue read sets the rate.
// Reset: synchronous, active high; all supervisor state takes its power-on
//   value and the queue empties.
// ----------------------------------------------------------------------------
module supervisor_watchdog_with_commands
  import swc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH   // result queue depth, at least 2
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] command
  input  logic        s_tuser,   // [0] action: 0 command byte, 1 one-second tick
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] value
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast
);

  // Input register: holds one beat until the queue has room for its worst
  // case of two results.
  logic       in_valid;
  logic       in_action;
  logic [7:0] in_command;
  logic       fire;
  logic       room2;

  swc_push_t  push;
  swc_res_t   head;

  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action  <= s_tuser;
      in_command <= s_tdata;
    end
  end

  // Decode and supervisor state: all work for one beat in a single pass.
  swc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .action  (in_action),
    .command (in_command),
    .push    (push)
  );

  // Result queue decouples the two sides, so a stalled master does not stop
  // intake until the queue is nearly full.
  swc_out_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room2 (room2),
    .valid (m_tvalid),
    .ready (m_tready),
    .head  (head)
  );

  assign m_tdata = head.value;
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

`ifndef SYNTHESIS
  a_hold_until_room: assert property (@(posedge clk) disable iff (rst)
    in_valid && !room2 |=> in_valid && $stable(in_command) && $stable(in_action))
    else $error("held input beat lost while queue full");
  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |-> push.count == 2'd0)
    else $error("result pushed without an item");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input stalled with empty input register");
`endif

endmodule

>>> hdl/swc_core.sv
// ----------------------------------------------------------------------------
// swc_core - command decode, supervisor state and timeout check
// Processes one registered item per cycle while fire is high, and emits up to two results.
// ----------------------------------------------------------------------------
module swc_core
  import swc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       action,
  input  logic [7:0] command,
  output swc_push_t  push
);

  logic        enabled,     enabled_next;
  logic        unlocked,    unlocked_next;
  logic [1:0]  set_mode,    set_mode_next;
  logic [6:0]  guard_base,  guard_base_next;
  logic [4:0]  guard_mult,  guard_mult_next;
  logic [6:0]  sleep_base,  sleep_base_next;
  logic [4:0]  sleep_mult,  sleep_mult_next;
  logic [6:0]  beacon_base, beacon_base_next;
  logic [4:0]  beacon_mult, beacon_mult_next;
  logic [15:0] elapsed_secs, elapsed_secs_next;
  logic [7:0]  primary_faults, primary_faults_next;

  logic [11:0] limit;
  logic [15:0] elapsed_inc;
  logic [7:0]  mult_diff;
  logic [4:0]  mult_val;
  logic [7:0]  base_diff;
  logic [2:0]  base_sel;
  logic [6:0]  base_val;
  swc_push_t   res;

  assign limit       = 12'(guard_base) * 12'(guard_mult);
  assign elapsed_inc = (elapsed_secs == 16'hFFFF) ? elapsed_secs : elapsed_secs + 16'd1;
  assign mult_diff   = command - MULT_OFFSET;
  assign mult_val    = mult_diff[4:0];
  // full selector kept so that 47..49 are caught before the table index wraps
  assign base_diff   = command - CMD_BASE_LO;
  assign base_sel    = base_diff[2:0];
  assign base_val    = base_lookup(base_sel);

  function automatic swc_push_t one(input logic [1:0] kind, input logic [15:0] value);
    swc_push_t p;
    p       = '0;
    p.count = 2'd1;
    p.res0  = '{kind: kind, value: value, last: 1'b1};
    return p;
  endfunction

  always_comb begin
    enabled_next        = enabled;
    unlocked_next       = unlocked;
    set_mode_next       = set_mode;
    guard_base_next     = guard_base;
    guard_mult_next     = guard_mult;
    sleep_base_next     = sleep_base;
    sleep_mult_next     = sleep_mult;
    beacon_base_next    = beacon_base;
    beacon_mult_next    = beacon_mult;
    elapsed_secs_next   = elapsed_secs;
    primary_faults_next = primary_faults;
    res                 = '0;

    if (action) begin
      elapsed_secs_next = elapsed_inc;
      if (enabled && (elapsed_inc > {4'd0, limit})) begin
        primary_faults_next = primary_faults + 8'd1;
        enabled_next     = 1'b0;
        unlocked_next    = 1'b0;
        set_mode_next    = MODE_GUARD;
        guard_base_next  = RST_GUARD_BASE;
        guard_mult_next  = RST_GUARD_MULT;
        sleep_base_next  = RST_SLEEP_BASE;
        sleep_mult_next  = RST_SLEEP_MULT;
        beacon_base_next = RST_BEACON_BASE;
        beacon_mult_next = RST_BEACON_MULT;
        elapsed_secs_next = '0;
        res.count = 2'd2;
        res.res0  = '{kind: KIND_REBOOT, value: 16'd0, last: 1'b0};
        res.res1  = '{kind: KIND_SELF,   value: 16'd0, last: 1'b1};
      end
    end else begin
      priority case (command) inside
        CMD_PING:    res = one(KIND_RESP, ST_PING);
        CMD_UNLOCK: begin
          unlocked_next = 1'b1;
          res = one(KIND_RESP, ST_SUCCESS);
        end
        CMD_LOCK: begin
          unlocked_next = 1'b0;
          res = one(KIND_RESP, ST_SUCCESS);
        end
        CMD_VERSION: res = one(KIND_RESP, VERSION_WORD);
        CMD_DATE:    res = one(KIND_RESP, DATE_WORD);
        CMD_REBOOT:  res = one(KIND_REBOOT, 16'd0);
        CMD_CLR_FAULTS: begin
          primary_faults_next = '0;
          res = one(KIND_RESP, ST_SUCCESS);
        end
        CMD_RD_FAULTS:  res = one(KIND_RESP, {8'd0, primary_faults});
        CMD_RD_FAULTS2: res = one(KIND_RESP, 16'd0);
        CMD_MODE_GUARD, CMD_MODE_SLEEP, CMD_MODE_BEAC: begin
          if (!unlocked) begin
            res = one(KIND_RESP, ST_LOCKED);
          end else if (command == CMD_MODE_GUARD) begin
            set_mode_next = MODE_GUARD;
          end else if (command == CMD_MODE_SLEEP) begin
            set_mode_next = MODE_SLEEP;
          end else begin
            set_mode_next = MODE_BEACON;
          end
        end
        CMD_SELF_RESET: begin
          enabled_next     = 1'b0;
          unlocked_next    = 1'b0;
          set_mode_next    = MODE_GUARD;
          guard_base_next  = RST_GUARD_BASE;
          guard_mult_next  = RST_GUARD_MULT;
          sleep_base_next  = RST_SLEEP_BASE;
          sleep_mult_next  = RST_SLEEP_MULT;
          beacon_base_next = RST_BEACON_BASE;
          beacon_mult_next = RST_BEACON_MULT;
          elapsed_secs_next = '0;
          res = one(KIND_SELF, 16'd0);
        end
        CMD_ENABLE: begin
          if (enabled) begin
            res = one(KIND_RESP, ST_INVALID);
          end else begin
            enabled_next      = 1'b1;
            elapsed_secs_next = '0;
            unlocked_next     = 1'b0;
            res = one(KIND_RESP, ST_SUCCESS);
          end
        end
        CMD_DISABLE: begin
          if (!enabled) begin
            res = one(KIND_RESP, ST_INVALID);
          end else begin
            enabled_next      = 1'b0;
            elapsed_secs_next = '0;
            unlocked_next     = 1'b0;
            res = one(KIND_RESP, ST_SUCCESS);
          end
        end
        CMD_HEARTBEAT: begin
          if (!enabled) begin
            res = one(KIND_RESP, ST_INVALID);
          end else begin
            elapsed_secs_next = '0;
            unlocked_next     = 1'b0;
            res = one(KIND_RESP, ST_SUCCESS);
          end
        end
        [CMD_BASE_LO:CMD_BASE_HI]: begin
          if (!unlocked) begin
            res = one(KIND_RESP, ST_LOCKED);
          end else if (base_diff >= {5'd0, BASE_ENTRIES}) begin
            res = one(KIND_RESP, ST_ERROR);
          end else begin
            unique case (set_mode)
              MODE_GUARD: begin
                guard_base_next = base_val;
                res = one(KIND_RESP, {9'd0, base_val});
              end
              MODE_SLEEP: begin
                sleep_base_next = base_val;
                res = one(KIND_RESP, {9'd0, base_val});
              end
              MODE_BEACON: begin
                beacon_base_next = base_val;
                res = one(KIND_RESP, ST_SUCCESS);
              end
              default: ; // mode three cannot be reached; no effect
            endcase
          end
        end
        [CMD_MULT_LO:CMD_MULT_HI]: begin
          if (!unlocked) begin
            res = one(KIND_RESP, ST_LOCKED);
          end else begin
            unique case (set_mode)
              MODE_GUARD: begin
                guard_mult_next = mult_val;
                res = one(KIND_RESP, {11'd0, mult_val});
              end
              MODE_SLEEP: begin
                sleep_mult_next = mult_val;
                res = one(KIND_RESP, {11'd0, mult_val});
              end
              MODE_BEACON: begin
                beacon_mult_next = mult_val;
                res = one(KIND_RESP, ST_SUCCESS);
              end
              default: ;
            endcase
          end
        end
        default: ; // unused code: silent
      endcase
    end
  end

  assign push = fire ? res : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled        <= 1'b0;
      unlocked       <= 1'b0;
      set_mode       <= MODE_GUARD;
      guard_base     <= RST_GUARD_BASE;
      guard_mult     <= RST_GUARD_MULT;
      sleep_base     <= RST_SLEEP_BASE;
      sleep_mult     <= RST_SLEEP_MULT;
      beacon_base    <= RST_BEACON_BASE;
      beacon_mult    <= RST_BEACON_MULT;
      elapsed_secs   <= '0;
      primary_faults <= '0;
    end else if (fire) begin
      enabled        <= enabled_next;
      unlocked       <= unlocked_next;
      set_mode       <= set_mode_next;
      guard_base     <= guard_base_next;
      guard_mult     <= guard_mult_next;
      sleep_base     <= sleep_base_next;
      sleep_mult     <= sleep_mult_next;
      beacon_base    <= beacon_base_next;
      beacon_mult    <= beacon_mult_next;
      elapsed_secs   <= elapsed_secs_next;
      primary_faults <= primary_faults_next;
    end
  end

`ifndef SYNTHESIS
  a_two_is_timeout: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.res0.kind == KIND_REBOOT && !push.res0.last
                           && push.res1.kind == KIND_SELF && push.res1.last)
    else $error("two-beat result is not reboot then self reset");
  a_timeout_disables: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |=> !enabled && elapsed_secs == 16'd0)
    else $error("state not cleared after timeout");
  a_mode_reachable: assert property (@(posedge clk) disable iff (rst)
    set_mode != 2'd3)
    else $error("interval mode holds an unreachable value");
`endif

endmodule

>>> hdl/swc_out_fifo.sv
// ----------------------------------------------------------------------------
// swc_out_fifo - result queue
// Takes up to two result beats per cycle, hands out one beat per cycle while ready is high.
// ----------------------------------------------------------------------------
module swc_out_fifo
  import swc_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  swc_push_t push,
  output logic      room2,
  output logic      valid,
  input  logic      ready,
  output swc_res_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  swc_res_t        mem [DEPTH];
  logic [AW-1:0]   wptr, wptr1, wptr2, rptr, rptr1;
  logic [CW-1:0]   count, count_next;
  logic            pop;

  assign wptr1 = (wptr == LAST_ADDR) ? '0 : wptr + AW'(1);
  assign wptr2 = (wptr1 == LAST_ADDR) ? '0 : wptr1 + AW'(1);
  assign rptr1 = (rptr == LAST_ADDR) ? '0 : rptr + AW'(1);

  assign valid = (count != '0);
  assign head  = mem[rptr];
  assign pop   = valid && ready;
  assign room2 = (count <= CW'(DEPTH - 2));

  assign count_next = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wptr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rptr <= rptr1;
      end
      if (push.count == 2'd1) begin
        wptr <= wptr1;
      end else if (push.count == 2'd2) begin
        wptr <= wptr2;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> count + CW'(push.count) <= CW'(DEPTH))
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");
`endif

endmodule
